// ----- hdl/bde_pkg.sv -----
// shared types, codes and constants for the b-spline de boor evaluator
// no dependencies
package bde_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_KNOTS_DEF  = 128;
  localparam int MAX_DEGREE_DEF = 5;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int          CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 1'b1;

  localparam logic [2:0]         DEGREE_RST     = 3'd3;
  localparam logic signed [31:0] MIN_HEIGHT_RST = 32'sd13107;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_POINT = 2'd1;
  localparam logic [1:0] ACT_KNOT  = 2'd2;
  localparam logic [1:0] ACT_EVAL  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] knot_value;
    logic signed [31:0] u_param;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               end_reached;
  } out_item_t;

  typedef enum logic [2:0] {
    K_CLEAR,
    K_POINT,
    K_DROP,
    K_KNOT,
    K_EVAL
  } kind_t;

  typedef struct packed {
    kind_t    kind;
    in_item_t item;
  } q_entry_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] count;
  } fr_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_END,
    S_CLAMP,
    S_SRCH,
    S_SRCH_W,
    S_LOAD,
    S_LOAD_W,
    S_KA,
    S_KB,
    S_KC,
    S_DIV,
    S_MUL,
    S_ADD,
    S_OUT
  } bk_state_t;

endpackage

// ----- hdl/bde_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module bde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bde_front.sv -----
// front end: accepts input transactions, classifies them, two entry queue
// depends on bde_pkg
module bde_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bde_pkg::in_item_t   in_data,
  input  logic signed [31:0]  min_height,
  output logic                q_valid,
  output bde_pkg::q_entry_t   q_head,
  input  logic                q_pop,
  output bde_pkg::fr_stat_t   fr_stat
);
  import bde_pkg::*;

  q_entry_t   ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push_ok, pop_ok;
  kind_t      kind;

  assign in_full = (count_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (count_r != 2'd0);
  assign pop_ok  = q_pop && q_valid;
  assign q_head  = ent_r[rd_ptr_r];

  assign fr_stat.busy  = q_valid;
  assign fr_stat.count = count_r;

  always_comb begin
    case (in_data.action)
      ACT_CLEAR: kind = K_CLEAR;
      ACT_POINT: kind = (in_data.point_z < min_height) ? K_DROP : K_POINT;
      ACT_KNOT:  kind = K_KNOT;
      ACT_EVAL:  kind = K_EVAL;
      default:   kind = K_EVAL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent_r[wr_ptr_r] <= '{kind: kind, item: in_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok)  rd_ptr_r <= ~rd_ptr_r;
      case ({push_ok, pop_ok})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hdl/bde_back.sv -----
// back end: point and knot stores, span search, divider and de boor sequencer
// depends on bde_pkg and bde_ram
module bde_back #(
  parameter int MAX_POINTS = bde_pkg::MAX_POINTS_DEF,
  parameter int MAX_KNOTS  = bde_pkg::MAX_KNOTS_DEF,
  parameter int MAX_DEGREE = bde_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bde_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          degree,
  input  logic                q_valid,
  input  bde_pkg::q_entry_t   q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output bde_pkg::out_item_t  out_data
);
  import bde_pkg::*;

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int KW    = $clog2(MAX_KNOTS);
  localparam int PCW   = $clog2(MAX_POINTS + 1);
  localparam int KCW   = $clog2(MAX_KNOTS + 1);
  localparam int CW    = ((KCW > PCW) ? KCW : PCW) + 2;
  localparam int LANES = MAX_DEGREE + 1;
  localparam int LW    = $clog2(LANES);
  localparam int AW    = FRAC_BITS + 1;
  localparam int DCW   = $clog2(FRAC_BITS + 1);
  localparam int PRW   = AW + 1 + 33;

  bk_state_t state_r, state_nxt;

  logic [PCW-1:0] pcount_r;
  logic [KCW-1:0] kcount_r;
  logic [PCW-1:0] k_r, lo_r, hi_r;
  logic [2:0]     j_r, r_r;
  logic signed [31:0] u_r, ustart_r, uend_r, kl_r;
  logic [32:0]    rem_r, den_r;
  logic [AW-1:0]  alpha_r;
  logic [DCW-1:0] dcnt_r;
  logic signed [31:0] dx_r [LANES];
  logic signed [31:0] dy_r [LANES];
  logic signed [31:0] dz_r [LANES];
  logic signed [31:0] cx_r, cy_r, cz_r, px_r, py_r, pz_r;
  logic signed [PRW-1:0] mx_r, my_r, mz_r;
  logic [1:0]     res_status_r;
  logic signed [31:0] res_x_r, res_y_r, res_z_r;
  logic           res_end_r;
  logic           out_valid_r;
  out_item_t      out_r;

  logic [CW-1:0]  cw_p, cw_np, idx_a, idx_b, mid;
  logic [CW-1:0]  kaddr;
  logic           pfull, kfull, traj_bad, out_free, take;
  logic           pwe, kwe;
  logic [31:0]    xr, yr, zr, kr;
  logic [LW-1:0]  lane_rd;
  logic signed [32:0] num_s, den_s;
  logic [32:0]    num_m, den_m;
  logic [33:0]    rem2;
  logic signed [PRW-1:0] nx, ny, nz;

  assign cw_p  = CW'(degree);
  assign cw_np = CW'(pcount_r);
  assign idx_a = CW'(k_r) - cw_p + CW'(j_r);
  assign idx_b = idx_a + cw_p + CW'(1) - CW'(r_r);
  assign mid   = (CW'(lo_r) + CW'(hi_r)) >> 1;
  assign pfull = (pcount_r == PCW'(MAX_POINTS));
  assign kfull = (kcount_r == KCW'(MAX_KNOTS));
  assign traj_bad = (degree == 3'd0) || (CW'(degree) > CW'(MAX_DEGREE)) ||
                    (pcount_r == '0) || (cw_np < cw_p + CW'(1)) ||
                    (CW'(kcount_r) < cw_np + cw_p + CW'(1));
  assign take     = (state_r == S_IDLE) && q_valid;
  assign q_pop    = take;
  assign out_free = !out_valid_r || out_pop;
  assign pwe = take && (q_head.kind == K_POINT) && !pfull;
  assign kwe = take && (q_head.kind == K_KNOT) && !kfull;
  assign lane_rd = (state_r == S_KB) ? LW'(j_r - 3'd1) : LW'(j_r);

  assign num_s = 33'(u_r) - 33'(kl_r);
  assign den_s = 33'($signed(kr)) - 33'(kl_r);
  assign num_m = num_s[32] ? 33'(-num_s) : 33'(num_s);
  assign den_m = den_s[32] ? 33'(-den_s) : 33'(den_s);
  assign rem2  = {rem_r, 1'b0};
  assign nx = PRW'(px_r) + (mx_r >>> FRAC_BITS);
  assign ny = PRW'(py_r) + (my_r >>> FRAC_BITS);
  assign nz = PRW'(pz_r) + (mz_r >>> FRAC_BITS);

  always_comb begin
    case (state_r)
      S_IDLE:  kaddr = cw_p;
      S_START: kaddr = cw_np;
      S_SRCH:  kaddr = mid;
      S_KB:    kaddr = idx_b;
      default: kaddr = idx_a;
    endcase
  end

  bde_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(pwe), .waddr(pcount_r[PW-1:0]), .wdata(q_head.item.point_x),
    .raddr(idx_a[PW-1:0]), .rdata(xr)
  );
  bde_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(pwe), .waddr(pcount_r[PW-1:0]), .wdata(q_head.item.point_y),
    .raddr(idx_a[PW-1:0]), .rdata(yr)
  );
  bde_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_z (
    .clk(clk), .we(pwe), .waddr(pcount_r[PW-1:0]), .wdata(q_head.item.point_z),
    .raddr(idx_a[PW-1:0]), .rdata(zr)
  );
  bde_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_ram_k (
    .clk(clk), .we(kwe), .waddr(kcount_r[KW-1:0]), .wdata(q_head.item.knot_value),
    .raddr(kaddr[KW-1:0]), .rdata(kr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_head.kind == K_EVAL && !traj_bad) state_nxt = S_START;
          else state_nxt = S_OUT;
        end
      end
      S_START: state_nxt = S_END;
      S_END:   state_nxt = S_CLAMP;
      S_CLAMP: begin
        if (uend_r <= ustart_r) state_nxt = S_OUT;
        else if (u_r >= uend_r || u_r <= ustart_r) state_nxt = S_LOAD;
        else state_nxt = S_SRCH;
      end
      S_SRCH:   state_nxt = ((CW'(hi_r) - CW'(lo_r)) > CW'(1)) ? S_SRCH_W : S_LOAD;
      S_SRCH_W: state_nxt = S_SRCH;
      S_LOAD:   state_nxt = S_LOAD_W;
      S_LOAD_W: state_nxt = (j_r == degree) ? S_KA : S_LOAD;
      S_KA:     state_nxt = S_KB;
      S_KB:     state_nxt = S_KC;
      S_KC: begin
        if (den_s != '0 && num_s != '0 && num_s[32] == den_s[32] && num_m < den_m)
          state_nxt = S_DIV;
        else
          state_nxt = S_MUL;
      end
      S_DIV:   state_nxt = (dcnt_r == DCW'(1)) ? S_MUL : S_DIV;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = (j_r == r_r && r_r == degree) ? S_OUT : S_KA;
      S_OUT:   state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // counts and output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r    <= '0;
      kcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        case (q_head.kind)
          K_CLEAR: begin
            pcount_r <= '0;
            kcount_r <= '0;
          end
          K_POINT: if (!pfull) pcount_r <= pcount_r + PCW'(1);
          K_KNOT:  if (!kfull) kcount_r <= kcount_r + KCW'(1);
          default: ;
        endcase
      end
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        res_x_r   <= '0;
        res_y_r   <= '0;
        res_z_r   <= '0;
        res_end_r <= 1'b0;
        u_r       <= q_head.item.u_param;
        case (q_head.kind)
          K_DROP:  res_status_r <= ST_DROPPED;
          K_POINT: res_status_r <= pfull ? ST_FULL : ST_OK;
          K_KNOT:  res_status_r <= kfull ? ST_FULL : ST_OK;
          K_EVAL:  res_status_r <= traj_bad ? ST_INVALID : ST_OK;
          default: res_status_r <= ST_OK;
        endcase
      end
      S_START: ustart_r <= $signed(kr);
      S_END:   uend_r   <= $signed(kr);
      S_CLAMP: begin
        j_r <= 3'd0;
        if (uend_r <= ustart_r) begin
          res_status_r <= ST_INVALID;
        end else begin
          res_end_r <= (u_r >= uend_r);
          lo_r <= PCW'(degree);
          hi_r <= pcount_r;
          if (u_r >= uend_r) begin
            u_r <= uend_r;
            k_r <= pcount_r - PCW'(1);
          end else if (u_r <= ustart_r) begin
            u_r <= ustart_r;
            k_r <= PCW'(degree);
          end
        end
      end
      S_SRCH: k_r <= lo_r;
      S_SRCH_W: begin
        if (u_r < $signed(kr)) hi_r <= PCW'(mid);
        else lo_r <= PCW'(mid);
      end
      S_LOAD_W: begin
        dx_r[LW'(j_r)] <= $signed(xr);
        dy_r[LW'(j_r)] <= $signed(yr);
        dz_r[LW'(j_r)] <= $signed(zr);
        if (j_r == degree) begin
          r_r <= 3'd1;
        end else begin
          j_r <= j_r + 3'd1;
        end
      end
      S_KA: begin
        cx_r <= dx_r[lane_rd];
        cy_r <= dy_r[lane_rd];
        cz_r <= dz_r[lane_rd];
      end
      S_KB: begin
        kl_r <= $signed(kr);
        px_r <= dx_r[lane_rd];
        py_r <= dy_r[lane_rd];
        pz_r <= dz_r[lane_rd];
      end
      S_KC: begin
        rem_r  <= num_m;
        den_r  <= den_m;
        dcnt_r <= DCW'(FRAC_BITS);
        alpha_r <= '0;
        if (den_s != '0 && num_s != '0 && num_s[32] == den_s[32] && num_m >= den_m)
          alpha_r <= AW'(1) << FRAC_BITS;
      end
      S_DIV: begin
        dcnt_r <= dcnt_r - DCW'(1);
        if (rem2 >= {1'b0, den_r}) begin
          rem_r   <= 33'(rem2 - {1'b0, den_r});
          alpha_r <= {alpha_r[AW-2:0], 1'b1};
        end else begin
          rem_r   <= rem2[32:0];
          alpha_r <= {alpha_r[AW-2:0], 1'b0};
        end
      end
      S_MUL: begin
        mx_r <= PRW'($signed({1'b0, alpha_r}) * (33'(cx_r) - 33'(px_r)));
        my_r <= PRW'($signed({1'b0, alpha_r}) * (33'(cy_r) - 33'(py_r)));
        mz_r <= PRW'($signed({1'b0, alpha_r}) * (33'(cz_r) - 33'(pz_r)));
      end
      S_ADD: begin
        dx_r[LW'(j_r)] <= nx[31:0];
        dy_r[LW'(j_r)] <= ny[31:0];
        dz_r[LW'(j_r)] <= nz[31:0];
        if (j_r > r_r) begin
          j_r <= j_r - 3'd1;
        end else if (r_r != degree) begin
          r_r <= r_r + 3'd1;
          j_r <= degree;
        end else begin
          res_x_r <= nx[31:0];
          res_y_r <= ny[31:0];
          res_z_r <= nz[31:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_r.status      <= res_status_r;
          out_r.pos_x       <= res_x_r;
          out_r.pos_y       <= res_y_r;
          out_r.pos_z       <= res_z_r;
          out_r.end_reached <= res_end_r;
        end
      end
      default: ;
    endcase
    if (state_r == S_LOAD_W && j_r == degree) j_r <= degree;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/bspline_de_boor_evaluator.sv -----
// top level of the b-spline de boor evaluator: config registers, front, back
// depends on bde_pkg, bde_front, bde_back, bde_ram
// clear, append point and append knot take the back end straight to the output state; an
// evaluate runs the span search, the point loads and the de boor steps, its time set by
// the bit-serial alpha divider and the single knot ram port; one transaction in the back
// end at a time
// the two entry input queue accepts while the back end works; one output register
// reset (synchronous, rst_n low) empties both stores, clears the queues and loads
// degree 3 and min height 0.2; stored data is not cleared
module bspline_de_boor_evaluator #(
  parameter int MAX_POINTS = bde_pkg::MAX_POINTS_DEF,
  parameter int MAX_KNOTS  = bde_pkg::MAX_KNOTS_DEF,
  parameter int MAX_DEGREE = bde_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bde_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  bde_pkg::in_item_t               in_data,
  output logic                            out_empty,
  input  logic                            out_pop,
  output bde_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [bde_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [31:0]                     cfg_data
);
  import bde_pkg::*;

  logic [2:0]         degree_r;
  logic signed [31:0] min_height_r;
  logic               q_valid, q_pop;
  q_entry_t           q_head;
  fr_stat_t           fr_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r     <= DEGREE_RST;
      min_height_r <= MIN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEGREE:     degree_r     <= cfg_data[2:0];
        CFG_MIN_HEIGHT: min_height_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  bde_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .min_height(min_height_r), .q_valid(q_valid),
    .q_head(q_head), .q_pop(q_pop), .fr_stat(fr_stat)
  );

  bde_back #(
    .MAX_POINTS(MAX_POINTS), .MAX_KNOTS(MAX_KNOTS),
    .MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .degree(degree_r), .q_valid(q_valid),
    .q_head(q_head), .q_pop(q_pop), .out_empty(out_empty),
    .out_pop(out_pop), .out_data(out_data)
  );

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> (fr_stat.busy && fr_stat.count == 2'd2))
    else $error("full without two queued transactions");

  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status != ST_OK) |->
      (out_data.pos_x == '0 && out_data.pos_y == '0 && out_data.pos_z == '0))
    else $error("nonzero position on failed transaction");

  a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.end_reached) |-> (out_data.status == ST_OK))
    else $error("end reached on failed transaction");

endmodule

// ----- sim/tb_bspline_de_boor_evaluator.sv -----
// self-checking testbench for the b-spline de boor evaluator
// depends on bde_pkg and bspline_de_boor_evaluator; queue handshakes, scoreboarded results
`timescale 1ns / 1ps

module tb_bspline_de_boor_evaluator;
  import bde_pkg::*;

  localparam int NPTS = 64;
  localparam int NKNOTS = 128;
  localparam int FRAC = 16;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_DEGREE;
  logic [31:0] cfg_data = '0;

  bspline_de_boor_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] px_mem [NPTS];
  logic signed [31:0] py_mem [NPTS];
  logic signed [31:0] pz_mem [NPTS];
  logic signed [31:0] knot_mem [NKNOTS];
  int unsigned n_pts, n_knots;
  int unsigned degree_m;
  logic signed [31:0] min_h_m;

  out_item_t pending_q [$];
  int errors = 0;
  int idle_cycles = 0;
  int unsigned n_sent = 0;
  bit hold_long = 1'b0;

  function automatic longint floor_shift(longint x);
    if (x >= 0) return x >>> FRAC;
    return -((-x + (64'sd1 << FRAC) - 1) >>> FRAC);
  endfunction

  function automatic out_item_t compute_position(in_item_t it);
    out_item_t r;
    longint dx [6], dy [6], dz [6];
    longint u, us, ue, kl, den, al, one;
    int unsigned n, k, lo, hi, mid, idx;
    r = '0;
    one = 64'sd1 << FRAC;
    case (it.action)
      ACT_CLEAR: begin
        n_pts = 0;
        n_knots = 0;
      end
      ACT_POINT: begin
        if (it.point_z < min_h_m) r.status = ST_DROPPED;
        else if (n_pts >= NPTS) r.status = ST_FULL;
        else begin
          px_mem[n_pts] = it.point_x;
          py_mem[n_pts] = it.point_y;
          pz_mem[n_pts] = it.point_z;
          n_pts++;
        end
      end
      ACT_KNOT: begin
        if (n_knots >= NKNOTS) r.status = ST_FULL;
        else begin
          knot_mem[n_knots] = it.knot_value;
          n_knots++;
        end
      end
      default: begin
        if (degree_m < 1 || degree_m > 5 || n_pts < degree_m + 1 ||
            n_knots < n_pts + degree_m + 1) begin
          r.status = ST_INVALID;
        end else begin
          n = n_pts - 1;
          us = knot_mem[degree_m];
          ue = knot_mem[n + 1];
          if (ue <= us) r.status = ST_INVALID;
          else begin
            u = it.u_param;
            r.end_reached = (u >= ue);
            if (u < us) u = us;
            if (u > ue) u = ue;
            if (u >= ue) k = n;
            else if (u <= us) k = degree_m;
            else begin
              lo = degree_m;
              hi = n + 1;
              while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (u < knot_mem[mid]) hi = mid;
                else lo = mid;
              end
              k = lo;
            end
            for (int j = 0; j <= degree_m; j++) begin
              dx[j] = px_mem[k - degree_m + j];
              dy[j] = py_mem[k - degree_m + j];
              dz[j] = pz_mem[k - degree_m + j];
            end
            for (int rr = 1; rr <= degree_m; rr++) begin
              for (int j = degree_m; j >= rr; j--) begin
                idx = k - degree_m + j;
                kl = knot_mem[idx];
                den = longint'(knot_mem[idx + degree_m + 1 - rr]) - kl;
                al = 0;
                if (den != 0) begin
                  al = ((u - kl) * one) / den;
                  if (al < 0) al = 0;
                  if (al > one) al = one;
                end
                dx[j] = dx[j-1] + floor_shift(al * (dx[j] - dx[j-1]));
                dy[j] = dy[j-1] + floor_shift(al * (dy[j] - dy[j-1]));
                dz[j] = dz[j-1] + floor_shift(al * (dz[j] - dz[j-1]));
              end
            end
            r.pos_x = dx[degree_m][31:0];
            r.pos_y = dy[degree_m][31:0];
            r.pos_z = dz[degree_m][31:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_pop && !out_empty) begin
      idle_cycles <= 0;
      if (pending_q.size() == 0) report_mismatch("unexpected transaction", 32'h0, 32'h0);
      else begin
        w = pending_q.pop_front();
        if (out_data.status !== w.status) report_mismatch("status", out_data.status, w.status);
        if (out_data.pos_x !== w.pos_x) report_mismatch("pos_x", out_data.pos_x, w.pos_x);
        if (out_data.pos_y !== w.pos_y) report_mismatch("pos_y", out_data.pos_y, w.pos_y);
        if (out_data.pos_z !== w.pos_z) report_mismatch("pos_z", out_data.pos_z, w.pos_z);
        if (out_data.end_reached !== w.end_reached)
          report_mismatch("end_reached", out_data.end_reached, w.end_reached);
      end
    end else if (rst_n && in_push && !in_full) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_pop <= 1'b0;
        for (int i = 0; i < 3000; i++) @(posedge clk);
        hold_long = 1'b0;
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          out_pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(in_item_t it, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_q = {pending_q, compute_position(it)};
    n_sent++;
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_DEGREE) degree_m = val[2:0];
    else min_h_m = val;
  endtask

  function automatic in_item_t make_item(logic [1:0] act, logic [31:0] a, logic [31:0] b,
                                         logic [31:0] c);
    in_item_t it;
    it.action = act;
    it.point_x = a;
    it.point_y = b;
    it.point_z = c;
    it.knot_value = a;
    it.u_param = a;
    return it;
  endfunction

  // builds a spline from random points and a mostly nondecreasing random knot vector
  task automatic load_spline(int unsigned np, bit burst);
    int unsigned nk;
    logic signed [31:0] kv;
    send_item(make_item(ACT_CLEAR, $urandom, $urandom, $urandom), burst);
    for (int i = 0; i < np; i++)
      send_item(make_item(ACT_POINT, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22),
                          $urandom, $urandom_range(3) == 0 ? $urandom :
                          min_h_m + $urandom_range(0, 1 << 20)), burst);
    nk = n_pts + degree_m + 1 + $urandom_range(0, 2);
    kv = -($urandom_range(0, 1 << 20));
    for (int i = 0; i < nk; i++) begin
      if ($urandom_range(9) == 0) kv = $urandom;
      else if ($urandom_range(3) != 0) kv = kv + $urandom_range(0, 1 << 18);
      send_item(make_item(ACT_KNOT, kv, $urandom, $urandom), burst);
    end
  endtask

  typedef struct {
    in_item_t it;
    bit typed;
    logic [1:0] st;
  } row_t;

  initial begin
    row_t rows [$];
    row_t rw;
    int unsigned sent;
    int unsigned degrees [5] = '{1, 5, 3, 0, 7};
    logic [31:0] heights [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd13107};
    n_pts = 0;
    n_knots = 0;
    degree_m = 3;
    min_h_m = 32'sd13107;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: extremes, error codes, every action
    rw.typed = 1; rw.st = ST_INVALID; rw.it = make_item(ACT_EVAL, 0, 0, 0); rows = {rows, rw};
    rw.st = ST_DROPPED; rw.it = make_item(ACT_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    rows = {rows, rw};
    rw.st = ST_OK; rw.it = make_item(ACT_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    rows = {rows, rw};
    for (int i = 0; i < 3; i++) begin
      rw.typed = 0; rw.it = make_item(ACT_POINT, i << 16, 32'hffff_0000 * i, 32'h7fff_0000);
      rows = {rows, rw};
    end
    rw.typed = 1; rw.st = ST_INVALID; rw.it = make_item(ACT_EVAL, 32'h1_0000, 0, 0);
    rows = {rows, rw};
    for (int i = 0; i < 8; i++) begin
      rw.typed = 1; rw.st = ST_OK;
      rw.it = make_item(ACT_KNOT, (i < 4) ? 32'd0 : (i == 4 ? 32'h2_0000 : 32'h7fff_ffff), 0, 0);
      rows = {rows, rw};
    end
    rw.typed = 0; rw.it = make_item(ACT_EVAL, 32'h8000_0000, 0, 0); rows = {rows, rw};
    rw.it = make_item(ACT_EVAL, 32'h7fff_ffff, 0, 0); rows = {rows, rw};
    rw.it = make_item(ACT_EVAL, 32'h1_8000, 0, 0); rows = {rows, rw};
    rw.it = make_item(ACT_EVAL, 32'h2_0000, 0, 0); rows = {rows, rw};
    rw.typed = 1; rw.st = ST_OK; rw.it = make_item(ACT_CLEAR, 32'hffff_ffff, 32'hffff_ffff,
                                                   32'hffff_ffff);
    rows = {rows, rw};
    rw.st = ST_INVALID; rw.it = make_item(ACT_EVAL, 0, 0, 0); rows = {rows, rw};
    foreach (rows[i]) begin
      send_item(rows[i].it, 1'b0);
      if (rows[i].typed && pending_q[$].status !== rows[i].st)
        report_mismatch("directed row", pending_q[$].status, rows[i].st);
    end
    drain_results();

    // store full on both stores
    for (int i = 0; i < NPTS + 1; i++)
      send_item(make_item(ACT_POINT, $urandom, $urandom, 32'h4000_0000), 1'b1);
    for (int i = 0; i < NKNOTS + 1; i++) send_item(make_item(ACT_KNOT, i << 12, 0, 0), 1'b1);
    send_item(make_item(ACT_EVAL, 32'h3_0000, 0, 0), 1'b0);
    drain_results();

    // random phases over several settings
    sent = n_sent;
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CFG_DEGREE, (ph < 5) ? degrees[ph] : $urandom_range(1, 5));
      write_reg(CFG_MIN_HEIGHT, (ph < 4) ? heights[ph] : $urandom_range(0, 1 << 16));
      cfg_we <= 1'b0;
      if (ph == 2) hold_long = 1'b1;
      do begin
        load_spline($urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : $urandom_range(1, 10),
                    ph == 2);
        for (int e = $urandom_range(3, 10); e > 0; e--) begin
          send_item(make_item($urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : ACT_EVAL,
                              $urandom_range(0, 1) ? $urandom :
                              knot_mem[$urandom_range(0, n_knots > 0 ? n_knots - 1 : 0)] +
                              $urandom_range(0, 1 << 16) - (1 << 15),
                              $urandom, $urandom), ph == 2);
        end
      end while (n_sent < sent + 30 * (ph + 1));
      drain_results();
    end

    in_push <= 1'b0;
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bde_pkg.sv
hdl/bde_ram.sv
hdl/bde_front.sv
hdl/bde_back.sv
hdl/bspline_de_boor_evaluator.sv
sim/tb_bspline_de_boor_evaluator.sv
